// ===== src/nuscs_pkg.sv =====
package nuscs_pkg;

	localparam int POS_W = 32;
	localparam int OUT_W = 32;
	localparam int TYPE_W = 5;
	localparam logic [7:0] TYPE_MASK = 8'h1F;
	localparam logic [7:0] ZERO_BYTE = 8'h00;
	localparam logic [7:0] ONE_BYTE = 8'h01;
	localparam logic [1:0] RUN_FULL = 2'd3;
	localparam logic [POS_W-1:0] CODE_BACK = POS_W'(3);
	localparam logic [POS_W-1:0] POS_MAX = '1;

	// The queue depth must be a power of two so that the pointers wrap by themselves.
	localparam int QDEPTH = 2;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = QPTR_W + 1;

	typedef struct packed {
		logic [7:0] data_byte;
		logic last_byte;
	} byte_t;

	typedef struct packed {
		logic [OUT_W-1:0] unit_offset;
		logic [OUT_W-1:0] unit_length;
		logic [TYPE_W-1:0] unit_type;
		logic final_unit;
		logic last_of_run;
	} unit_t;

	typedef struct packed {
		logic [POS_W-1:0] off;
		logic [POS_W-1:0] len;
		logic [TYPE_W-1:0] utype;
	} res_t;

	typedef struct packed {
		logic close_v;
		res_t close_r;
		logic fin_v;
		res_t fin_r;
	} entry_t;

endpackage

// ===== src/nuscs_front.sv =====
module nuscs_front (
	input logic clk,
	input logic arst_n,
	input logic byte_valid,
	output logic byte_stall,
	input nuscs_pkg::byte_t byte_data,
	output logic push,
	output nuscs_pkg::entry_t push_entry,
	input logic queue_full
);
	import nuscs_pkg::*;

	logic [1:0] zero_run_q;
	logic header_pending_q;
	logic [POS_W-1:0] byte_position_q;
	logic [POS_W-1:0] current_start_q;
	logic [TYPE_W-1:0] current_type_q;
	logic unit_open_q;
	logic [POS_W-1:0] pending_start_q;

	logic [1:0] zr_n;
	logic hp_n;
	logic [POS_W-1:0] cs_n;
	logic [TYPE_W-1:0] ct_n;
	logic uo_n;
	logic [POS_W-1:0] ps_n;
	logic [POS_W-1:0] end_pos;
	logic [7:0] masked;
	logic accept;
	entry_t ent;

	assign byte_stall = queue_full;
	assign accept = byte_valid && !queue_full;
	assign masked = byte_data.data_byte & TYPE_MASK;

	always_comb begin
		zr_n = zero_run_q;
		hp_n = header_pending_q;
		cs_n = current_start_q;
		ct_n = current_type_q;
		uo_n = unit_open_q;
		ps_n = pending_start_q;
		ent = '0;
		if (header_pending_q) begin
			ent.close_v = unit_open_q;
			ent.close_r.off = current_start_q;
			ent.close_r.len = pending_start_q - current_start_q;
			ent.close_r.utype = current_type_q;
			cs_n = pending_start_q;
			ct_n = masked[TYPE_W-1:0];
			uo_n = 1'b1;
			hp_n = 1'b0;
			zr_n = '0;
		end else if (byte_data.data_byte == ZERO_BYTE) begin
			if (zero_run_q != RUN_FULL) begin
				zr_n = zero_run_q + 2'd1;
			end
		end else if (byte_data.data_byte == ONE_BYTE && zero_run_q == RUN_FULL) begin
			ps_n = byte_position_q - CODE_BACK;
			hp_n = 1'b1;
			zr_n = '0;
		end else begin
			zr_n = '0;
		end
		end_pos = (byte_position_q == POS_MAX) ? byte_position_q
			: byte_position_q + POS_W'(1);
		if (byte_data.last_byte) begin
			ent.fin_v = uo_n && (ct_n != '0);
			ent.fin_r.off = cs_n;
			ent.fin_r.len = end_pos - cs_n;
			ent.fin_r.utype = ct_n;
		end
	end

	assign push = accept && (ent.close_v || ent.fin_v);
	assign push_entry = ent;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			zero_run_q <= '0;
			header_pending_q <= 1'b0;
			byte_position_q <= '0;
			current_start_q <= '0;
			current_type_q <= '0;
			unit_open_q <= 1'b0;
			pending_start_q <= '0;
		end else if (accept) begin
			if (byte_data.last_byte) begin
				zero_run_q <= '0;
				header_pending_q <= 1'b0;
				byte_position_q <= '0;
				current_start_q <= '0;
				current_type_q <= '0;
				unit_open_q <= 1'b0;
				pending_start_q <= '0;
			end else begin
				zero_run_q <= zr_n;
				header_pending_q <= hp_n;
				byte_position_q <= end_pos;
				current_start_q <= cs_n;
				current_type_q <= ct_n;
				unit_open_q <= uo_n;
				pending_start_q <= ps_n;
			end
		end
	end

endmodule

// ===== src/nuscs_queue.sv =====
module nuscs_queue (
	input logic clk,
	input logic arst_n,
	input logic push,
	input nuscs_pkg::entry_t push_entry,
	output logic full,
	input logic pop,
	output logic head_valid,
	output nuscs_pkg::entry_t head_entry
);
	import nuscs_pkg::*;

	entry_t mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	assign full = (count_q == QCNT_W'(QDEPTH));
	assign head_valid = (count_q != '0);
	assign head_entry = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + QCNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - QCNT_W'(1);
			end
		end
	end

endmodule

// ===== src/nuscs_back.sv =====
module nuscs_back (
	input logic clk,
	input logic arst_n,
	input logic head_valid,
	input nuscs_pkg::entry_t head_entry,
	output logic pop,
	output logic unit_valid,
	input logic unit_stall,
	output nuscs_pkg::unit_t unit_data
);
	import nuscs_pkg::*;

	logic out_valid_q;
	unit_t out_q;
	logic second_q;
	logic load;
	logic split;
	logic use_fin;
	res_t sel;

	assign load = !out_valid_q || !unit_stall;
	assign split = head_entry.close_v && head_entry.fin_v && !second_q;
	assign use_fin = second_q || !head_entry.close_v;
	assign sel = use_fin ? head_entry.fin_r : head_entry.close_r;
	assign pop = load && head_valid && !split;

	always_ff @(posedge clk) begin
		if (load && head_valid) begin
			out_q.unit_offset <= OUT_W'(sel.off);
			out_q.unit_length <= OUT_W'(sel.len);
			out_q.unit_type <= sel.utype;
			out_q.final_unit <= use_fin;
			out_q.last_of_run <= !split;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			second_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= head_valid;
			if (head_valid) begin
				second_q <= split;
			end
		end
	end

	assign unit_valid = out_valid_q;
	assign unit_data = out_q;

endmodule

// ===== src/nal_unit_start_code_splitter.sv =====
// Annex B start code splitter.
// The byte channel (byte_valid, byte_stall, byte_data) takes one stream byte per
// transfer, with last_byte marking the final byte of a stream buffer. The unit channel
// (unit_valid, unit_stall, unit_data) gives offset, length and type of each unit
// found, one result per transfer; last_of_run marks the last result caused by a byte.
// A byte is taken in every cycle while the two-entry result queue has room, so the
// sustained rate is one byte per cycle. A byte that closes a unit shows its result on
// the unit channel through the queue and the output register: the transfer writes the
// queue, and the output register loads the result once it is free. A byte that yields
// two results, a header byte that is also the last byte, gives them one after the other.
// When the receiver stalls, the output register holds its result, the queue fills and
// byte_stall rises once the queue is full; bytes that yield no result never enter it.
// Reset clears the scanner state, the queue and the output valid at once; after
// the last byte of a stream the scanner returns to its reset state and the next byte
// starts a new stream at offset zero.
module nal_unit_start_code_splitter (
	input logic clk,
	input logic arst_n,
	input logic byte_valid,
	output logic byte_stall,
	input nuscs_pkg::byte_t byte_data,
	output logic unit_valid,
	input logic unit_stall,
	output nuscs_pkg::unit_t unit_data
);
	import nuscs_pkg::*;

	logic push;
	entry_t push_entry;
	logic queue_full;
	logic pop;
	logic head_valid;
	entry_t head_entry;

	nuscs_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.byte_valid(byte_valid),
		.byte_stall(byte_stall),
		.byte_data(byte_data),
		.push(push),
		.push_entry(push_entry),
		.queue_full(queue_full)
	);

	nuscs_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.push_entry(push_entry),
		.full(queue_full),
		.pop(pop),
		.head_valid(head_valid),
		.head_entry(head_entry)
	);

	nuscs_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.head_valid(head_valid),
		.head_entry(head_entry),
		.pop(pop),
		.unit_valid(unit_valid),
		.unit_stall(unit_stall),
		.unit_data(unit_data)
	);

endmodule

// ===== src/nuscs_checker.sv =====
module nuscs_checker (
	input logic clk,
	input logic arst_n,
	input logic byte_valid,
	input logic byte_stall,
	input nuscs_pkg::byte_t byte_data,
	input logic unit_valid,
	input logic unit_stall,
	input nuscs_pkg::unit_t unit_data
);
	import nuscs_pkg::*;

	a_byte_hold: assert property (@(posedge clk) disable iff (!arst_n)
		byte_valid && byte_stall |=> byte_valid && $stable(byte_data))
		else $error("Stalled byte changed.");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		unit_valid && unit_stall |=> unit_valid && $stable(unit_data))
		else $error("Stalled result changed.");

	a_final_typed: assert property (@(posedge clk) disable iff (!arst_n)
		unit_valid && unit_data.final_unit |-> unit_data.unit_type != '0)
		else $error("Final unit reported with type zero.");

	a_final_last: assert property (@(posedge clk) disable iff (!arst_n)
		unit_valid && unit_data.final_unit |-> unit_data.last_of_run)
		else $error("Final unit is not the last result of its byte.");

	a_pair: assert property (@(posedge clk) disable iff (!arst_n)
		unit_valid && !unit_stall && !unit_data.last_of_run
		|=> unit_valid && unit_data.final_unit)
		else $error("First of two results not followed by the final unit.");

endmodule

bind nal_unit_start_code_splitter nuscs_checker u_nuscs_checker (
	.clk(clk),
	.arst_n(arst_n),
	.byte_valid(byte_valid),
	.byte_stall(byte_stall),
	.byte_data(byte_data),
	.unit_valid(unit_valid),
	.unit_stall(unit_stall),
	.unit_data(unit_data)
);

// ===== verif/nal_unit_start_code_splitter_tb.sv =====
`timescale 1ns / 1ps

module nal_unit_start_code_splitter_tb;
	import nuscs_pkg::*;

	localparam int DIRECTED_BYTES = 30;
	localparam int RAND_BYTES = 1000;
	localparam int HOLD_LEN = 300;
	localparam int DRAIN_CYCLES = 20;
	localparam int CYCLE_LIMIT = 200000;
	localparam int BY_SCANNER = -1;

	typedef struct {
		byte_t b;
		int known;
		unit_t e0;
		unit_t e1;
	} plan_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic byte_valid = 1'b0;
	logic byte_stall;
	byte_t byte_data = '0;
	logic unit_valid;
	logic unit_stall = 1'b0;
	unit_t unit_data;

	plan_t byte_plan[$];
	unit_t units_due[$];
	int taken = 0;
	int total_bytes = 1;
	int errors = 0;
	int cycles = 0;
	int hold_left = 0;
	bit hold_done = 1'b0;

	logic [1:0] sc_zeros;
	logic sc_hdr_wait;
	logic [POS_W-1:0] sc_pos;
	logic [POS_W-1:0] sc_start;
	logic [POS_W-1:0] sc_pend;
	logic [TYPE_W-1:0] sc_type;
	logic sc_open;

	nal_unit_start_code_splitter dut (
		.clk(clk),
		.arst_n(arst_n),
		.byte_valid(byte_valid),
		.byte_stall(byte_stall),
		.byte_data(byte_data),
		.unit_valid(unit_valid),
		.unit_stall(unit_stall),
		.unit_data(unit_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic unit_t mk_unit(logic [POS_W-1:0] off, logic [POS_W-1:0] len,
			logic [TYPE_W-1:0] ut, logic fin, logic lor);
		unit_t u;
		u.unit_offset = OUT_W'(off);
		u.unit_length = OUT_W'(len);
		u.unit_type = ut;
		u.final_unit = fin;
		u.last_of_run = lor;
		return u;
	endfunction

	task automatic scan_clear();
		sc_zeros = '0;
		sc_hdr_wait = 1'b0;
		sc_pos = '0;
		sc_start = '0;
		sc_pend = '0;
		sc_type = '0;
		sc_open = 1'b0;
	endtask

	task automatic scan_byte(input byte_t b, input bit keep);
		logic [POS_W-1:0] pos;
		unit_t got [2];
		int n;
		n = 0;
		pos = sc_pos;
		if (sc_hdr_wait) begin
			if (sc_open) begin
				got[n] = mk_unit(sc_start, sc_pend - sc_start, sc_type, 1'b0, 1'b0);
				n++;
			end
			sc_start = sc_pend;
			sc_type = TYPE_W'(b.data_byte & TYPE_MASK);
			sc_open = 1'b1;
			sc_hdr_wait = 1'b0;
			sc_zeros = '0;
		end else if (b.data_byte == ZERO_BYTE) begin
			if (sc_zeros != RUN_FULL)
				sc_zeros = sc_zeros + 2'd1;
		end else if (b.data_byte == ONE_BYTE && sc_zeros == RUN_FULL) begin
			sc_pend = pos - CODE_BACK;
			sc_hdr_wait = 1'b1;
			sc_zeros = '0;
		end else begin
			sc_zeros = '0;
		end
		sc_pos = (pos == POS_MAX) ? pos : pos + POS_W'(1);
		if (b.last_byte) begin
			if (sc_open && sc_type != '0) begin
				got[n] = mk_unit(sc_start, sc_pos - sc_start, sc_type, 1'b1, 1'b0);
				n++;
			end
			scan_clear();
		end
		if (n > 0)
			got[n-1].last_of_run = 1'b1;
		if (keep)
			for (int i = 0; i < n; i++)
				units_due.push_back(got[i]);
	endtask

	task automatic put_known(input logic [7:0] d, input logic l, input int n,
			input unit_t e0, input unit_t e1);
		plan_t p;
		p.b.data_byte = d;
		p.b.last_byte = l;
		p.known = n;
		p.e0 = e0;
		p.e1 = e1;
		byte_plan.push_back(p);
	endtask

	task automatic put(input logic [7:0] d, input logic l);
		put_known(d, l, BY_SCANNER, '0, '0);
	endtask

	function automatic logic [7:0] body_byte();
		case ($urandom_range(0, 9))
			0, 1: return ZERO_BYTE;
			2: return ONE_BYTE;
			default: return 8'($urandom());
		endcase
	endfunction

	task automatic gen_unit_stream();
		int units;
		int zeros;
		bit ended;
		units = $urandom_range(0, 4);
		ended = 1'b0;
		repeat ($urandom_range(0, 3)) put(body_byte(), 1'b0);
		for (int u = 0; u < units && !ended; u++) begin
			if ($urandom_range(0, 7) == 0) begin
				put(ZERO_BYTE, 1'b0);
				put(ZERO_BYTE, 1'b0);
				put(ONE_BYTE, 1'b0);
			end
			zeros = ($urandom_range(0, 3) == 0) ? $urandom_range(4, 7) : 3;
			repeat (zeros) put(ZERO_BYTE, 1'b0);
			if (u == units - 1 && $urandom_range(0, 5) == 0) begin
				put(ONE_BYTE, 1'b1);
				ended = 1'b1;
			end else begin
				put(ONE_BYTE, 1'b0);
				if (u == units - 1 && $urandom_range(0, 4) == 0) begin
					put(8'($urandom()), 1'b1);
					ended = 1'b1;
				end else begin
					put(8'($urandom()), 1'b0);
					repeat ($urandom_range(0, 10)) put(body_byte(), 1'b0);
				end
			end
		end
		if (!ended)
			put(body_byte(), 1'b1);
	endtask

	task automatic gen_noise_stream();
		repeat ($urandom_range(1, 20)) put(8'($urandom()), $urandom_range(0, 15) == 0);
		put(8'($urandom()), 1'b1);
	endtask

	function automatic int idle_pct(input bit rx);
		int phase;
		phase = (taken * 3) / total_bytes;
		if (phase == 0)
			return rx ? 52 : 9;
		if (phase == 1)
			return rx ? 9 : 52;
		return 0;
	endfunction

	task automatic check_unit(input unit_t want, input unit_t seen);
		if (seen.unit_offset !== want.unit_offset) begin
			$display("%0t: unit_offset expected %0d, got %0d", $time,
				want.unit_offset, seen.unit_offset);
			errors++;
		end
		if (seen.unit_length !== want.unit_length) begin
			$display("%0t: unit_length expected %0d, got %0d", $time,
				want.unit_length, seen.unit_length);
			errors++;
		end
		if (seen.unit_type !== want.unit_type) begin
			$display("%0t: unit_type expected %0d, got %0d", $time,
				want.unit_type, seen.unit_type);
			errors++;
		end
		if (seen.final_unit !== want.final_unit) begin
			$display("%0t: final_unit expected %0b, got %0b", $time,
				want.final_unit, seen.final_unit);
			errors++;
		end
		if (seen.last_of_run !== want.last_of_run) begin
			$display("%0t: last_of_run expected %0b, got %0b", $time,
				want.last_of_run, seen.last_of_run);
			errors++;
		end
	endtask

	always @(posedge clk) begin
		plan_t cur;
		unit_t want;
		if (arst_n) begin
			if (byte_valid && !byte_stall) begin
				cur = byte_plan.pop_front();
				scan_byte(cur.b, cur.known == BY_SCANNER);
				if (cur.known > 0)
					units_due.push_back(cur.e0);
				if (cur.known > 1)
					units_due.push_back(cur.e1);
				taken <= taken + 1;
			end
			if (!byte_valid || !byte_stall) begin
				if (byte_plan.size() != 0 && $urandom_range(0, 99) >= idle_pct(1'b0)) begin
					byte_valid <= 1'b1;
					byte_data <= byte_plan[0].b;
				end else begin
					byte_valid <= 1'b0;
				end
			end
			if (unit_valid && !unit_stall) begin
				if (units_due.size() == 0) begin
					$display("%0t: unexpected unit offset %0d length %0d type %0d", $time,
						unit_data.unit_offset, unit_data.unit_length, unit_data.unit_type);
					errors++;
				end else begin
					want = units_due.pop_front();
					check_unit(want, unit_data);
				end
			end
		end
	end

	// Once, early in the last phase, the receiver holds off long enough for the
	// result queue to fill while bytes keep coming.
	always @(posedge clk) begin
		if (arst_n) begin
			if (hold_left != 0) begin
				unit_stall <= 1'b1;
				hold_left <= hold_left - 1;
			end else if (!hold_done && taken * 3 >= total_bytes * 2 + 60) begin
				hold_done <= 1'b1;
				hold_left <= HOLD_LEN;
				unit_stall <= 1'b1;
			end else begin
				unit_stall <= ($urandom_range(0, 99) < idle_pct(1'b1));
			end
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	initial begin
		scan_clear();

		// Long zero run: the start code is the last four bytes.
		put(ZERO_BYTE, 1'b0);
		put(ZERO_BYTE, 1'b0);
		put(ZERO_BYTE, 1'b0);
		put(ZERO_BYTE, 1'b0);
		put(ONE_BYTE, 1'b0);
		put_known(8'h65, 1'b0, 0, '0, '0);
		put(ZERO_BYTE, 1'b0);
		put(ZERO_BYTE, 1'b0);
		put(ZERO_BYTE, 1'b0);
		put(ONE_BYTE, 1'b0);
		// A zero header byte opens a type zero unit and does not count as a zero.
		put_known(ZERO_BYTE, 1'b0, 1,
			mk_unit(POS_W'(1), POS_W'(5), TYPE_W'(5), 1'b0, 1'b1), '0);
		put(ZERO_BYTE, 1'b0);
		put(ZERO_BYTE, 1'b0);
		put(ONE_BYTE, 1'b0);
		// The type zero unit is not reported at the end of the stream.
		put_known(8'hC2, 1'b1, 0, '0, '0);
		// A stream without any header gives nothing.
		put_known(8'h7F, 1'b1, 0, '0, '0);
		put(ZERO_BYTE, 1'b0);
		put(ZERO_BYTE, 1'b0);
		put(ZERO_BYTE, 1'b0);
		put(ONE_BYTE, 1'b0);
		put(8'hBF, 1'b0);
		put(ZERO_BYTE, 1'b0);
		put(ZERO_BYTE, 1'b0);
		put(ZERO_BYTE, 1'b0);
		put(ONE_BYTE, 1'b0);
		put_known(8'h41, 1'b0, 1,
			mk_unit(POS_W'(0), POS_W'(5), TYPE_W'(31), 1'b0, 1'b1), '0);
		put(ZERO_BYTE, 1'b0);
		put(ZERO_BYTE, 1'b0);
		put(ZERO_BYTE, 1'b0);
		// The stream ends on a start code with no header after it.
		put_known(ONE_BYTE, 1'b1, 1,
			mk_unit(POS_W'(5), POS_W'(9), TYPE_W'(1), 1'b1, 1'b1), '0);

		while (byte_plan.size() < DIRECTED_BYTES + RAND_BYTES) begin
			if ($urandom_range(0, 99) < 85)
				gen_unit_stream();
			else
				gen_noise_stream();
		end
		total_bytes = byte_plan.size();

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		while (byte_plan.size() != 0 || byte_valid || units_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
